// ----- rtl/core/fsd_pkg.sv -----
// Shared types, constants and helpers for the RGB Floyd-Steinberg dither.
// No dependencies; imported by fsd_ctrl, fsd_datapath and the top level.
package fsd_pkg;

  localparam int FSD_MAX_WIDTH = 4096;
  localparam int NUM_CH        = 3;
  localparam int CH_W          = 8;
  localparam int ERR_W         = 9;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 13;
  localparam int IMG_W_W       = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_QUANT_STEPS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 1'd1;

  localparam logic [CH_W-1:0]    QUANT_STEPS_RST = 8'd1;
  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST = 13'd640;

  typedef logic [NUM_CH-1:0][CH_W-1:0]  rgb_pix_t;
  typedef logic [NUM_CH-1:0][ERR_W-1:0] rgb_err_t;

  typedef struct packed {
    logic accept;
    logic dif_a;
    logic dif_b;
    logic scale;
    logic div;
    logic mul;
    logic commit;
  } fsd_cmd_t;

  typedef struct packed {
    logic out_free;
  } fsd_status_t;

  // floor(255/s) per step count; entry 0 matches entry 1
  typedef logic [7:0] step_lut_t [256];

  function automatic step_lut_t build_step_lut();
    step_lut_t lut;
    int        cnt;
    for (int s = 0; s < 256; s++) begin
      cnt = 0;
      for (int k = 1; k < 256; k++) begin
        if (k * s <= 255) cnt++;
      end
      lut[s] = 8'(cnt);
    end
    return lut;
  endfunction

  localparam step_lut_t STEP_LUT = build_step_lut();

  // pix + k/16 * err, rounded half up, clamped to 0..255
  function automatic logic [7:0] diffuse(input logic [7:0] pix,
                                         input logic signed [8:0] err,
                                         input logic [2:0] k);
    logic signed [13:0] t;
    t = $signed({2'b00, pix, 4'b0000}) + 14'($signed({1'b0, k})) * 14'(err) + 14'sd8;
    if (t[13]) begin
      return 8'd0;
    end else if (t[12:4] > 9'd255) begin
      return 8'hFF;
    end else begin
      return t[11:4];
    end
  endfunction

endpackage

// ----- rtl/core/fsd_ctrl.sv -----
// Per-pixel sequencer for the dither: steps one pixel through the datapath.
// Depends on fsd_pkg (command and status structs).
module fsd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fsd_pkg::fsd_status_t status,
  output fsd_pkg::fsd_cmd_t    cmd
);
  import fsd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIF_A,
    S_DIF_B,
    S_SCALE,
    S_DIV,
    S_MUL,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DIF_A;
        end
      end
      S_DIF_A: begin
        cmd.dif_a = 1'b1;
        state_nxt = S_DIF_B;
      end
      S_DIF_B: begin
        cmd.dif_b = 1'b1;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register can take the beat
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ----- rtl/core/fsd_datapath.sv -----
// Dither datapath: config registers, line buffer, error diffusion,
// quantizer and output register. Depends on fsd_pkg.
module fsd_datapath #(
  parameter int MAX_WIDTH = fsd_pkg::FSD_MAX_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fsd_pkg::fsd_cmd_t                 cmd,
  output fsd_pkg::fsd_status_t              status,
  input  logic                              cfg_valid,
  input  logic [fsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fsd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_start_of_frame,
  input  logic [7:0]                        in_red_in,
  input  logic [7:0]                        in_green_in,
  input  logic [7:0]                        in_blue_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_red_out,
  output logic [7:0]                        out_green_out,
  output logic [7:0]                        out_blue_out
);
  import fsd_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int CW = (XW + 1 > IMG_W_W) ? XW + 1 : IMG_W_W;

  // config
  logic [7:0]         quant_steps_r;
  logic [IMG_W_W-1:0] image_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quant_steps_r <= QUANT_STEPS_RST;
      image_width_r <= IMAGE_WIDTH_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_QUANT_STEPS) quant_steps_r <= cfg_data[7:0];
      if (cfg_index == CFG_IMAGE_WIDTH) image_width_r <= cfg_data[IMG_W_W-1:0];
    end
  end

  logic [7:0]    s_eff;
  logic [CW-1:0] w_raw, w_eff;

  always_comb begin
    s_eff = (quant_steps_r == 8'd0) ? 8'd1 : quant_steps_r;
    w_raw = CW'(image_width_r);
    if (w_raw == '0) begin
      w_eff = CW'(1);
    end else if (w_raw > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
  end

  // row position
  logic [XW-1:0] col_r, x_r;
  logic          first_row_r;
  logic          has_left_r, has_up_r, has_ur_r, last_r;
  logic [XW-1:0] acc_x;
  logic [XW:0]   acc_x1;
  logic          acc_last;

  always_comb begin
    acc_x    = in_start_of_frame ? '0 : col_r;
    acc_x1   = {1'b0, acc_x} + (XW+1)'(1);
    acc_last = !(CW'(acc_x1) < w_eff);
  end

  // line buffer of previous-row errors
  rgb_err_t mem [MAX_WIDTH];
  rgb_err_t above_q, ur_q;
  rgb_err_t left_err_r, held_ul_r, cur_err;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      above_q <= mem[acc_x];
      ur_q    <= mem[acc_x1[XW-1:0]];
    end
    if (cmd.commit) begin
      mem[x_r] <= cur_err;
    end
  end

  // per-channel arithmetic
  rgb_pix_t                     v_r, ua_v, dif_a_v, ub_v, dif_b_v;
  logic [NUM_CH-1:0][16:0]      n_r, n_nxt;
  logic [NUM_CH-1:0][7:0]       qidx_r, qidx_nxt, q_r, q_nxt;
  logic [NUM_CH-1:0][15:0]      sv_prod, lev_prod;
  logic [NUM_CH-1:0][15:0]      m;
  logic [NUM_CH-1:0][24:0]      recip;
  logic [NUM_CH-1:0][8:0]       q0;
  logic [NUM_CH-1:0][17:0]      rem;
  logic [7:0]                   step_size;

  assign step_size = STEP_LUT[s_eff];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      ua_v[c]    = (has_up_r && has_left_r) ?
                   diffuse(v_r[c], $signed(held_ul_r[c]), 3'd1) : v_r[c];
      dif_a_v[c] = has_up_r ? diffuse(ua_v[c], $signed(above_q[c]), 3'd5) : ua_v[c];
      ub_v[c]    = has_ur_r ? diffuse(v_r[c], $signed(ur_q[c]), 3'd3) : v_r[c];
      dif_b_v[c] = has_left_r ? diffuse(ub_v[c], $signed(left_err_r[c]), 3'd7) : ub_v[c];

      // n = 2*s*v + 255
      sv_prod[c] = 16'(s_eff) * 16'(v_r[c]);
      n_nxt[c]   = {sv_prod[c], 1'b0} + 17'd255;

      // n/510 = (n>>1)/255: reciprocal estimate, then one correction
      m[c]        = n_r[c][16:1];
      recip[c]    = {1'b0, m[c], 8'b0} + 25'(m[c]);
      q0[c]       = recip[c][24:16];
      rem[c]      = 18'(m[c]) - (18'({q0[c], 8'b0}) - 18'(q0[c]));
      qidx_nxt[c] = (rem[c] >= 18'd255) ? 8'(q0[c] + 9'd1) : q0[c][7:0];

      lev_prod[c] = 16'(qidx_r[c]) * 16'(step_size);
      q_nxt[c]    = lev_prod[c][7:0];

      cur_err[c]  = {1'b0, v_r[c]} - {1'b0, q_r[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      v_r        <= {in_blue_in, in_green_in, in_red_in};
      x_r        <= acc_x;
      has_left_r <= (acc_x != '0);
      has_up_r   <= !(in_start_of_frame || first_row_r);
      has_ur_r   <= !(in_start_of_frame || first_row_r) && !acc_last;
      last_r     <= acc_last;
    end
    if (cmd.dif_a) v_r <= dif_a_v;
    if (cmd.dif_b) v_r <= dif_b_v;
    if (cmd.scale) n_r <= n_nxt;
    if (cmd.div)   qidx_r <= qidx_nxt;
    if (cmd.mul)   q_r <= q_nxt;
    if (cmd.commit) begin
      held_ul_r <= last_r ? '0 : above_q;
      left_err_r <= last_r ? '0 : cur_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      first_row_r <= 1'b1;
    end else if (cmd.commit) begin
      if (last_r) begin
        col_r       <= '0;
        first_row_r <= 1'b0;
      end else begin
        col_r       <= x_r + XW'(1);
        first_row_r <= !has_up_r;
      end
    end
  end

  // output register
  logic       out_valid_r;
  logic [7:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      red_r   <= q_r[0];
      green_r <= q_r[1];
      blue_r  <= q_r[2];
    end
  end

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_red_out     = red_r;
  assign out_green_out   = green_r;
  assign out_blue_out    = blue_r;

endmodule

// ----- rtl/core/floyd_steinberg_rgb_dither.sv -----
// RGB888 Floyd-Steinberg dither, top level. Uses fsd_pkg, fsd_ctrl, fsd_datapath.
// The sequencer takes the input beat, runs two diffusion steps, the scale multiply,
// the divide by 510 and the level multiply, then waits until the output register is
// free and commits; out_valid rises after the commit. No new beat is taken meanwhile.
// Reset (rst_n, sync, active low) clears control state and config to defaults;
// the line buffer is not cleared, the first row of each frame does not use its contents.
module floyd_steinberg_rgb_dither #(
  parameter int MAX_WIDTH = fsd_pkg::FSD_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fsd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_start_of_frame,
  input  logic [7:0]                      in_red_in,
  input  logic [7:0]                      in_green_in,
  input  logic [7:0]                      in_blue_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_red_out,
  output logic [7:0]                      out_green_out,
  output logic [7:0]                      out_blue_out
);
  import fsd_pkg::*;

  fsd_cmd_t    cmd;
  fsd_status_t status;

  assign cfg_ready = 1'b1;

  fsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  fsd_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_valid         (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_start_of_frame (in_start_of_frame),
    .in_red_in         (in_red_in),
    .in_green_in       (in_green_in),
    .in_blue_in        (in_blue_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_red_out       (out_red_out),
    .out_green_out     (out_green_out),
    .out_blue_out      (out_blue_out)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a pixel is in flight");

  a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("output beat appeared without a commit");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.dif_a, cmd.dif_b, cmd.scale, cmd.div, cmd.mul,
              cmd.commit}))
    else $error("more than one datapath command active");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> status.out_free)
    else $error("commit while output register is occupied");
`endif

endmodule

// ----- tb/tb_floyd_steinberg_rgb_dither.sv -----
// Self-checking testbench for floyd_steinberg_rgb_dither: random-paced pixel frames
// against a behavioral Floyd-Steinberg predictor. Depends on fsd_pkg and the top level.
module tb_floyd_steinberg_rgb_dither;
  import fsd_pkg::*;

  typedef logic signed [ERR_W-1:0] chan_err_t;
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_QUANT_STEPS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_start_of_frame = 1'b0;
  logic [7:0]            in_red_in = '0;
  logic [7:0]            in_green_in = '0;
  logic [7:0]            in_blue_in = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_red_out;
  logic [7:0]            out_green_out;
  logic [7:0]            out_blue_out;

  floyd_steinberg_rgb_dither dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_start_of_frame (in_start_of_frame),
    .in_red_in         (in_red_in),
    .in_green_in       (in_green_in),
    .in_blue_in        (in_blue_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_red_out       (out_red_out),
    .out_green_out     (out_green_out),
    .out_blue_out      (out_blue_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state, mirrors the block after reset
  logic [7:0]  steps_reg = QUANT_STEPS_RST;
  logic [12:0] width_reg = IMAGE_WIDTH_RST;
  chan_err_t   line_err [FSD_MAX_WIDTH][NUM_CH] = '{default: '0};
  chan_err_t   left_err [NUM_CH] = '{default: '0};
  chan_err_t   upleft_err [NUM_CH] = '{default: '0};
  int          col = 0;
  bit          first_row = 1'b1;

  pixel_t      expected_pixels [$];
  int unsigned fail_count = 0;
  int          tx_max = 11;
  int          rx_max = 11;

  function automatic int eff_width(input logic [12:0] w);
    if (w == 0) return 1;
    if (w > FSD_MAX_WIDTH) return FSD_MAX_WIDTH;
    return int'(w);
  endfunction

  // pix + k/16 * err, round half up, clamp to 0..255
  function automatic int spread(input int pix, input int err, input int k);
    int t;
    t = pix * 16 + err * k + 8;
    if (t < 0) return 0;
    t = t / 16;
    return (t > 255) ? 255 : t;
  endfunction

  function automatic int level_of(input int v, input int s);
    int q;
    q = (2 * s * v + 255) / 510;
    return q * (255 / s);
  endfunction

  function automatic pixel_t dither_pixel(input logic sof, input pixel_t src);
    int        w, s, x, v, q, c;
    bit        has_left, has_up, has_ur;
    chan_err_t above [NUM_CH];
    chan_err_t cur [NUM_CH];
    logic [7:0] chan [NUM_CH];
    pixel_t    res;
    w = eff_width(width_reg);
    s = (steps_reg == 0) ? 1 : int'(steps_reg);
    if (sof) begin
      col = 0;
      first_row = 1'b1;
    end
    x = col % FSD_MAX_WIDTH;
    has_left = x > 0;
    has_up = !first_row;
    has_ur = has_up && (x + 1 < w);
    chan = '{src.red, src.green, src.blue};
    for (c = 0; c < NUM_CH; c++) begin
      above[c] = line_err[x][c];
      v = int'(chan[c]);
      if (has_up) begin
        if (has_left) v = spread(v, upleft_err[c], 1);
        v = spread(v, above[c], 5);
        if (has_ur) v = spread(v, line_err[(x + 1) % FSD_MAX_WIDTH][c], 3);
      end
      if (has_left) v = spread(v, left_err[c], 7);
      q = level_of(v, s);
      cur[c] = chan_err_t'(v - q);
      chan[c] = 8'(q);
    end
    upleft_err = above;
    line_err[x] = cur;
    left_err = cur;
    // past the row end (also after a width shrink): wrap to a new row
    if (x + 1 >= w) begin
      col = 0;
      first_row = 1'b0;
      left_err = '{default: '0};
      upleft_err = '{default: '0};
    end else begin
      col = x + 1;
    end
    res.red = chan[0];
    res.green = chan[1];
    res.blue = chan[2];
    return res;
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7, 0))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == CFG_QUANT_STEPS) steps_reg = data[7:0];
    else if (idx == CFG_IMAGE_WIDTH) width_reg = data[12:0];
  endtask

  task automatic send_pixel(input logic sof, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    int     gap;
    pixel_t px;
    gap = (tx_max == 0) ? 0 : $urandom_range(tx_max, 0);
    // valid stays up across back-to-back beats
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_of_frame <= sof;
    in_red_in <= r;
    in_green_in <= g;
    in_blue_in <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    px = '{r, g, b};
    expected_pixels.push_back(dither_pixel(sof, px));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  // result side: random stall per beat, then compare with the oldest prediction
  initial begin : result_monitor
    int     hold;
    pixel_t want;
    forever begin
      hold = (rx_max == 0) ? 0 : $urandom_range(rx_max, 0);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      if (expected_pixels.size() == 0) begin
        fail_count++;
        $error("result beat with no pixel pending");
      end else begin
        want = expected_pixels.pop_front();
        check_field("red_out", want.red, out_red_out);
        check_field("green_out", want.green, out_green_out);
        check_field("blue_out", want.blue, out_blue_out);
      end
    end
  end

  task automatic test_defaults();
    tx_max = 11;
    rx_max = 11;
    send_pixel(1'b1, 8'd0, 8'd0, 8'd0);
    send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
    send_pixel(1'b0, 8'd127, 8'd128, 8'd129);
  endtask

  // zero steps and zero width, then the largest step count on a 2x2 frame
  task automatic test_step_extremes();
    drain();
    write_reg(CFG_QUANT_STEPS, 13'd0);
    write_reg(CFG_IMAGE_WIDTH, 13'd0);
    send_pixel(1'b1, 8'd200, 8'd100, 8'd50);
    send_pixel(1'b0, 8'd128, 8'd127, 8'd1);
    send_pixel(1'b0, 8'd254, 8'd1, 8'd255);
    drain();
    write_reg(CFG_QUANT_STEPS, 13'd255);
    write_reg(CFG_IMAGE_WIDTH, 13'd2);
    send_pixel(1'b1, 8'd255, 8'd0, 8'd128);
    send_pixel(1'b0, 8'd1, 8'd254, 8'd77);
    send_pixel(1'b0, 8'd255, 8'd255, 8'd0);
    send_pixel(1'b0, 8'd0, 8'd3, 8'd250);
  endtask

  // column already past the new width: that pixel closes its row
  task automatic test_width_shrink_mid_row();
    int i;
    drain();
    tx_max = 0;
    write_reg(CFG_QUANT_STEPS, 13'd3);
    write_reg(CFG_IMAGE_WIDTH, 13'd3);
    for (i = 0; i < 5; i++) send_pixel(i == 0, rand_chan(), rand_chan(), rand_chan());
    drain();
    write_reg(CFG_IMAGE_WIDTH, 13'd1);
    for (i = 0; i < 3; i++) send_pixel(1'b0, rand_chan(), rand_chan(), rand_chan());
  endtask

  // width register above the limit saturates; one full row plus a few below it
  task automatic test_full_width_row();
    int i;
    drain();
    tx_max = 0;
    rx_max = 0;
    write_reg(CFG_QUANT_STEPS, 13'($urandom_range(255, 1)));
    write_reg(CFG_IMAGE_WIDTH, 13'h1FFF);
    for (i = 0; i < FSD_MAX_WIDTH + 6; i++) begin
      send_pixel(i == 0, rand_chan(), rand_chan(), rand_chan());
    end
  endtask

  task automatic test_random_frames();
    int         sent, phase, steps, new_w, old_eff, new_eff, rows, frame_len;
    int         npix, pos, i, c;
    bit         need_sof, flat;
    logic       sof;
    logic [7:0] base [NUM_CH];
    logic [7:0] pix [NUM_CH];
    sent = 0;
    phase = 0;
    base = '{default: '0};
    flat = 1'b0;
    while (sent < 1700) begin
      drain();
      case ($urandom_range(3, 0))
        0: begin tx_max = 0;  rx_max = 0;  end
        1: begin tx_max = 11; rx_max = 0;  end
        2: begin tx_max = 0;  rx_max = 11; end
        default: begin tx_max = 11; rx_max = 11; end
      endcase
      case ($urandom_range(9, 0))
        0: steps = 0;
        1: steps = 255;
        2: steps = 1;
        3, 4, 5: steps = $urandom_range(7, 2);
        default: steps = $urandom_range(255, 1);
      endcase
      write_reg(CFG_QUANT_STEPS, 13'(steps));
      old_eff = eff_width(width_reg);
      need_sof = $urandom_range(3, 0) != 0;
      if (phase == 0 || $urandom_range(3, 0) != 0) begin
        case ($urandom_range(9, 0))
          0: new_w = 0;
          1: new_w = 1;
          2: new_w = $urandom_range(80, 41);
          3, 4, 5: new_w = $urandom_range(40, 9);
          default: new_w = $urandom_range(8, 2);
        endcase
        write_reg(CFG_IMAGE_WIDTH, 13'(new_w));
        // a wider row would read line buffer entries not yet written
        if (eff_width(width_reg) > old_eff || phase == 0) need_sof = 1'b1;
      end
      new_eff = eff_width(width_reg);
      rows = (new_eff > 40) ? $urandom_range(3, 2) : $urandom_range(6, 2);
      frame_len = new_eff * rows;
      npix = frame_len * $urandom_range(2, 1) + $urandom_range(3, 0);
      if (npix > 240) npix = 240;
      pos = need_sof ? 0 : 1;
      for (i = 0; i < npix; i++) begin
        sof = (pos == 0) || ($urandom_range(63, 0) == 0);
        if (sof) begin
          pos = 0;
          flat = $urandom_range(2, 0) == 0;
          for (c = 0; c < NUM_CH; c++) base[c] = rand_chan();
        end
        for (c = 0; c < NUM_CH; c++) begin
          pix[c] = (flat && $urandom_range(3, 0) != 0) ? base[c] : rand_chan();
        end
        send_pixel(sof, pix[0], pix[1], pix[2]);
        pos = (pos + 1) % frame_len;
      end
      sent += npix;
      phase++;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_step_extremes();
    test_width_shrink_mid_row();
    test_full_width_row();
    test_random_frames();
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("floyd_steinberg_rgb_dither test passed");
    end else begin
      $display("floyd_steinberg_rgb_dither test failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("floyd_steinberg_rgb_dither test failed");
    $finish;
  end

endmodule
